[rtl/core/trwt_pkg.sv]
package trwt_pkg;

  // Window geometry
  localparam int WINDOW_DEPTH = 61;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

  // Field widths
  localparam int TEMP_W = 12;
  localparam int TIME_W = 32;
  localparam int WIN_W  = 22;
  localparam int RATE_W = 29;
  localparam int DIFF_W = TEMP_W + 1;
  localparam int MAG_W  = 28;
  localparam int STEP_W = $clog2(MAG_W);

  // Scaling and validity limits, 1/16 degC
  localparam logic [15:0]              RATE_SCALE   = 16'd60000;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW     = -12'sd880;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH    = 12'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_POWERON = 12'sd1360;

  localparam logic [WIN_W-1:0] WINDOW_MS_RESET = 22'd60000;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic write;
    logic drop;
    logic mul;
    logic div_step;
    logic rate_clear;
    logic rate_load;
    logic out_load;
  } trwt_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic ok;
    logic age_over;
    logic rate_zero;
  } trwt_sts_t;

endpackage

[rtl/core/temperature_rate_window_tracker.sv]
// Channel   Direction  Handshake            Payload
// in_       slave      in_tvalid/in_tready  in_tdata: sample, now_ms
// out_      master     out_tvalid/out_tready out_tdata: temperature, rate, window_count;
//                                           out_tuser: sample_ok
// cfg_      write      cfg_wr_en            cfg_wr_data: window_ms
//
// One item at a time. An invalid sample goes from the check straight to the output state.
// A valid one is written, then the oldest entry is read and evaluated, again per evicted
// entry, and the rate is then either cleared or computed by the 28-step restoring divider;
// eviction walks the store's read port.
// Reset (synchronous, rst_n low) empties the window, clears the rate and sets window_ms
// to 60000; the store itself needs no clearing pass.
// A stalled result stays in the output register; a new item is taken meanwhile and
// waits before its own result beat until the register is free.
module temperature_rate_window_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [11:0] sample, [43:12] now_ms, [47:44] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [11:0] temperature, [40:12] rate,
                                  // [46:41] window_count, [47] zero
  output logic        out_tuser,  // [0] sample_ok
  input  logic        cfg_wr_en,
  input  logic [21:0] cfg_wr_data
);
  import trwt_pkg::*;

  trwt_cmd_t                cmd;
  trwt_sts_t                sts;
  logic signed [TEMP_W-1:0] temperature;
  logic signed [RATE_W-1:0] rate;
  logic [5:0]               window_count;

  trwt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  trwt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_sample        (in_tdata[11:0]),
    .in_now_ms        (in_tdata[43:12]),
    .cmd              (cmd),
    .sts              (sts),
    .out_sample_ok    (out_tuser),
    .out_temperature  (temperature),
    .out_rate         (rate),
    .out_window_count (window_count)
  );

  assign out_tdata = {1'b0, window_count, rate, temperature};

endmodule

[rtl/core/trwt_ctrl.sv]
module trwt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  trwt_pkg::trwt_sts_t sts,
  output trwt_pkg::trwt_cmd_t cmd
);
  import trwt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  // Sequencer: next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = sts.ok ? S_WRITE : S_OUT;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.age_over) begin
          cmd.drop  = 1'b1;
          state_nxt = S_READ;
        end else if (sts.rate_zero) begin
          cmd.rate_clear = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          cmd.mul   = 1'b1;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(MAG_W - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.rate_load = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The result beat stays offered until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The divider never runs past its last quotient bit
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> step_r < STEP_W'(MAG_W))
    else $error("divider step count out of range");

  // A new result is only loaded when the output stage is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result beat overwritten");

  // A drop is only issued while evaluating the oldest entry
  a_drop_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop |-> state_r == S_EVAL)
    else $error("drop outside evaluation");

endmodule

[rtl/core/trwt_dp.sv]
module trwt_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [trwt_pkg::WIN_W-1:0]        cfg_wr_data,
  input  logic signed [trwt_pkg::TEMP_W-1:0] in_sample,
  input  logic [trwt_pkg::TIME_W-1:0]       in_now_ms,
  input  trwt_pkg::trwt_cmd_t               cmd,
  output trwt_pkg::trwt_sts_t               sts,
  output logic                              out_sample_ok,
  output logic signed [trwt_pkg::TEMP_W-1:0] out_temperature,
  output logic signed [trwt_pkg::RATE_W-1:0] out_rate,
  output logic [5:0]                        out_window_count
);
  import trwt_pkg::*;

  localparam int ENTRY_W = TIME_W + TEMP_W;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [WIN_W-1:0]         window_r;
  logic signed [TEMP_W-1:0] s_r;
  logic [TIME_W-1:0]        now_r;
  logic [PTR_W-1:0]         oldest_r, oldest_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [ENTRY_W-1:0]       mem [WINDOW_DEPTH];
  logic [ENTRY_W-1:0]       rd_r;
  logic signed [RATE_W-1:0] rate_r;

  logic                     full;
  logic [PTR_W-1:0]         base;
  logic [CNT_W-1:0]         cnt_base;
  logic [PTR_W:0]           slot_sum;
  logic [PTR_W-1:0]         slot;
  logic [TIME_W-1:0]        rd_time;
  logic signed [TEMP_W-1:0] rd_temp;
  logic [TIME_W-1:0]        age;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_mag;
  logic                     neg_r;
  logic [MAG_W-1:0]         num_r;
  logic [TIME_W-1:0]        dt_r;
  logic [TIME_W-1:0]        rem_r;
  logic [MAG_W-1:0]         quo_r;
  logic [TIME_W:0]          rem_sh;
  logic                     rem_ge;
  logic [TIME_W:0]          rem_sub;
  logic [RATE_W-1:0]        quo_ext;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_MS_RESET;
    end else if (cfg_wr_en) begin
      window_r <= cfg_wr_data;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r   <= in_sample;
      now_r <= in_now_ms;
    end
  end

  assign sts.ok = (s_r >= TEMP_LOW) && (s_r <= TEMP_HIGH) && (s_r != TEMP_POWERON);

  // Slot for the new entry, after dropping the oldest when full
  assign full     = (fill_r == CNT_W'(WINDOW_DEPTH));
  assign base     = full ? ptr_inc(oldest_r) : oldest_r;
  assign cnt_base = full ? CNT_W'(WINDOW_DEPTH - 1) : fill_r;
  assign slot_sum = {1'b0, base} + (PTR_W+1)'(cnt_base);
  assign slot     = (slot_sum >= (PTR_W+1)'(WINDOW_DEPTH)) ?
                    PTR_W'(slot_sum - (PTR_W+1)'(WINDOW_DEPTH)) : slot_sum[PTR_W-1:0];

  // Pointer and fill count
  always_comb begin
    oldest_nxt = oldest_r;
    fill_nxt   = fill_r;
    if (cmd.write) begin
      oldest_nxt = base;
      fill_nxt   = cnt_base + 1'b1;
    end else if (cmd.drop) begin
      oldest_nxt = ptr_inc(oldest_r);
      fill_nxt   = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      fill_r   <= '0;
    end else begin
      oldest_r <= oldest_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Window store: one write port, oldest entry read every cycle
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[slot] <= {now_r, s_r};
    end
    rd_r <= mem[oldest_r];
  end

  assign rd_time = rd_r[ENTRY_W-1:TEMP_W];
  assign rd_temp = rd_r[TEMP_W-1:0];
  assign age     = now_r - rd_time;

  assign sts.age_over  = (fill_r > CNT_W'(1)) && (age > TIME_W'(window_r));
  assign sts.rate_zero = (fill_r <= CNT_W'(1)) || (age == '0);

  // Temperature difference, sign and magnitude
  assign diff     = DIFF_W'(s_r) - DIFF_W'(rd_temp);
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // Restoring divider, one quotient bit a cycle
  assign rem_sh  = {rem_r, num_r[MAG_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dt_r};
  assign rem_sub = rem_sh - {1'b0, dt_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      neg_r <= diff[DIFF_W-1];
      num_r <= MAG_W'(diff_mag) * MAG_W'(RATE_SCALE);
      dt_r  <= age;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[MAG_W-2:0], 1'b0};
      rem_r <= rem_ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
      quo_r <= {quo_r[MAG_W-2:0], rem_ge};
    end
  end

  // Held rate
  assign quo_ext = RATE_W'(quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= '0;
    end else if (cmd.rate_clear) begin
      rate_r <= '0;
    end else if (cmd.rate_load) begin
      rate_r <= neg_r ? $signed(-quo_ext) : $signed(quo_ext);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_ok    <= sts.ok;
      out_temperature  <= sts.ok ? s_r : '0;
      out_rate         <= rate_r;
      out_window_count <= 6'(fill_r);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW_DEPTH))
    else $error("window fill count beyond depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oldest_r < PTR_W'(WINDOW_DEPTH))
    else $error("oldest pointer beyond depth");

  // The newest entry is never evicted
  a_keep_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop |-> fill_r > CNT_W'(1))
    else $error("eviction would empty the window");

endmodule

[bench/temperature_rate_window_tracker_tb.sv]
module temperature_rate_window_tracker_tb;
  import trwt_pkg::*;

  // One result beat as the tracker should present it.
  typedef struct packed {
    logic                     ok;
    logic signed [TEMP_W-1:0] temp;
    logic signed [RATE_W-1:0] rate;
    logic [CNT_W-1:0]         count;
  } reading_result_t;

  // The longest item evicts entries and runs the divider.
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD     = 400;
  localparam int PRINT_CAP     = 100;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en;
  logic [21:0] cfg_wr_data;

  // Mirror of the window, the held rate and the window length.
  logic signed [TEMP_W-1:0] temp_hist [WINDOW_DEPTH];
  logic [TIME_W-1:0]        stamp_hist [WINDOW_DEPTH];
  int                       win_head;
  int                       win_fill;
  logic signed [RATE_W-1:0] rate_held;
  logic [WIN_W-1:0]         window_len;

  reading_result_t pending_readings [$];
  int              errors;
  int              send_idle_pct;
  int              recv_idle_pct;
  bit              hold_req;
  int              hold_left;

  temperature_rate_window_tracker DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up if the run hangs.
  initial begin
    #16000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void drop_oldest_reading();
    win_head = (win_head + 1) % WINDOW_DEPTH;
    win_fill--;
  endfunction

  // Works out the result beat for one accepted reading and updates the mirror.
  function automatic reading_result_t predict_reading(input logic signed [TEMP_W-1:0] smp,
                                                      input logic [TIME_W-1:0] stamp);
    reading_result_t   res;
    logic [TIME_W-1:0] age;
    int                slot;
    int                diff;
    longint            quotient;
    res.ok = (smp >= TEMP_LOW) && (smp <= TEMP_HIGH) && (smp != TEMP_POWERON);
    if (res.ok) begin
      if (win_fill >= WINDOW_DEPTH) drop_oldest_reading();
      slot = (win_head + win_fill) % WINDOW_DEPTH;
      temp_hist[slot]  = smp;
      stamp_hist[slot] = stamp;
      win_fill++;
      // Ages wrap modulo 2^32, so a later stamp looks very old.
      age = stamp - stamp_hist[win_head];
      while (win_fill > 1 && age > window_len) begin
        drop_oldest_reading();
        age = stamp - stamp_hist[win_head];
      end
      if (win_fill > 1 && age != '0) begin
        diff      = int'(smp) - int'(temp_hist[win_head]);
        quotient  = longint'(diff) * longint'(RATE_SCALE) / longint'(age);
        rate_held = quotient[RATE_W-1:0];
      end else begin
        rate_held = '0;
      end
    end
    res.temp  = res.ok ? smp : '0;
    res.rate  = rate_held;
    res.count = win_fill[CNT_W-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    errors++;
    if (errors <= PRINT_CAP)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Each result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      reading_result_t want;
      if (pending_readings.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: unexpected result beat, expected none, got tdata %h tuser %b",
                   $time, out_tdata, out_tuser);
      end else begin
        want = pending_readings.pop_front();
        if (out_tuser !== want.ok)
          flag_mismatch("sample_ok", longint'(want.ok), longint'(out_tuser));
        if (out_tdata[11:0] !== want.temp)
          flag_mismatch("temperature", longint'(want.temp), longint'($signed(out_tdata[11:0])));
        if (out_tdata[40:12] !== want.rate)
          flag_mismatch("rate", longint'(want.rate), longint'($signed(out_tdata[40:12])));
        if (out_tdata[46:41] !== want.count)
          flag_mismatch("window_count", longint'(want.count), longint'(out_tdata[46:41]));
      end
    end
  end

  // Offers one reading and waits until it is accepted; called and returns at a falling edge.
  task automatic send_reading(input int smp, input logic [TIME_W-1:0] stamp);
    logic signed [TEMP_W-1:0] raw;
    raw = smp[TEMP_W-1:0];
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, stamp, raw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_readings.push_back(predict_reading(raw, stamp));
    @(negedge clk);
  endtask

  // Waits until every expected beat has arrived and the tracker has settled.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] len);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    window_len  = len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // A drifting probe with the odd marker, noise, repeated or backward stamp and jump.
  task automatic run_stream(input int n_items, input int s_pct, input int r_pct,
                            input logic [WIN_W-1:0] len, input int step_max);
    int                cur;
    int                smp;
    int                pick;
    logic [TIME_W-1:0] stamp;
    set_window(len);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    cur   = int'($urandom_range(2880)) - 880;
    stamp = $urandom;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        smp   = int'($urandom_range(4095)) - 2048;
        stamp = stamp + $urandom_range(step_max);
      end else if (pick < 11) begin
        smp   = (pick == 8) ? 1360 : -2032;
        stamp = stamp + $urandom_range(step_max);
      end else begin
        if (pick < 14) begin
          cur = cur + int'($urandom_range(20)) - 10;
        end else if (pick < 16) begin
          stamp = stamp - $urandom_range(5000);
        end else if (pick < 18) begin
          stamp = stamp + $urandom;
        end else if (pick < 21) begin
          cur   = $urandom_range(1) ? -880 : 2000;
          stamp = stamp + $urandom_range(step_max);
        end else if (pick < 26) begin
          cur   = int'($urandom_range(2880)) - 880;
          stamp = stamp + $urandom_range(step_max);
        end else begin
          cur   = cur + int'($urandom_range(80)) - 40;
          stamp = stamp + $urandom_range(step_max);
        end
        if (cur < -880) cur = -880;
        if (cur > 2000) cur = 2000;
        if (cur == 1360) cur = 1361;
        smp = cur;
      end
      send_reading(smp, stamp);
    end
  endtask

  // Validity limits, markers, the single sample, wrap and a backward stamp.
  task automatic test_sample_limits();
    logic [TIME_W-1:0] t0;
    t0 = 32'hFFFF_F000;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_reading(-880, t0);
    send_reading(2000, t0 + 1000);
    send_reading(-881, t0 + 1100);
    send_reading(2001, t0 + 1200);
    send_reading(1360, t0 + 1300);
    send_reading(-2032, t0 + 1400);
    send_reading(-2048, t0 + 1500);
    send_reading(2047, t0 + 1600);
    send_reading(1359, t0 + 2000);
    send_reading(1361, t0 + 5000);
    send_reading(0, t0 + 3000);
    send_reading(100, t0 - 10);
    send_reading(-1, t0 - 10);
  endtask

  // Zero, one and the widest window lengths, then short random runs at the ends.
  task automatic test_window_extremes();
    logic [TIME_W-1:0] t1;
    t1 = 32'h1234_5678;
    set_window(22'd0);
    send_reading(500, t1);
    send_reading(600, t1);
    send_reading(700, t1 + 1);
    set_window(22'd1);
    send_reading(800, t1 + 10);
    send_reading(900, t1 + 11);
    send_reading(1000, t1 + 12);
    set_window(22'h3F_FFFF);
    send_reading(-880, t1 + 100);
    send_reading(2000, t1 + 100 + 32'h3F_FFFF);
    send_reading(0, t1 + 101 + 32'h3F_FFFF);
    set_window(22'd3600000);
    send_reading(-880, t1 + 32'h0100_0000);
    send_reading(2000, t1 + 32'h0100_0001);
    run_stream(100, 10, 10, 22'd1, 2);
    run_stream(100, 10, 10, 22'h3F_FFFF, 200000);
  endtask

  // The receiver holds off for a long stretch while readings keep coming.
  task automatic test_output_stall();
    logic [TIME_W-1:0] stamp;
    set_window(22'd60000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stamp    = $urandom;
    hold_req = 1'b1;
    repeat (16) begin
      stamp = stamp + $urandom_range(1500);
      send_reading(int'($urandom_range(2000)) - 880, stamp);
    end
  endtask

  // Random streams under each idling pattern.
  task automatic test_idle_mix();
    run_stream(450, 22, 70, 22'd60000, 2000);
    run_stream(450, 70, 22, 22'd3600000, 90000);
    run_stream(450, 0, 0, 22'd5000, 400);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    win_head      = 0;
    win_fill      = 0;
    rate_held     = '0;
    window_len    = WINDOW_MS_RESET;
    errors        = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_sample_limits();
    test_window_extremes();
    test_output_stall();
    test_idle_mix();
    wait_idle();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
